### rtl/lrr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, action codes and types of the line and rectangle rasterizer.
package lrr_pkg;

    // Default coordinate width and fixed field widths.
    localparam int COORD_BITS_DEF = 8;
    localparam int ACT_BITS       = 2;
    localparam int RECT_BITS      = 8;

    // Action codes carried on the item channel.
    localparam logic [ACT_BITS-1:0] ACT_LINE    = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_OUTLINE = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_FILLED  = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_NEXT    = 2'd3;

    // Outline segments, drawn in this order.
    localparam logic [RECT_BITS-1:0] SEG_TOP    = 8'd0;
    localparam logic [RECT_BITS-1:0] SEG_LEFT   = 8'd1;
    localparam logic [RECT_BITS-1:0] SEG_BOTTOM = 8'd2;
    localparam logic [RECT_BITS-1:0] SEG_RIGHT  = 8'd3;

    // Orientation of a prepared line.
    typedef struct packed {
        logic steep;
        logic minor_down;
    } line_dir_t;

    // Per-item status from the stepper to the output register.
    typedef struct packed {
        logic emit;
        logic ink;
        logic done;
    } pix_flags_t;

endpackage

### rtl/lrr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for shape items and emitted pixels.
interface lrr_item_if
    import lrr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [ACT_BITS-1:0]   action;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [RECT_BITS-1:0]  rect_width;
    logic [RECT_BITS-1:0]  rect_height;
    logic                  ink;

    modport source (
        output valid, action, start_x, start_y, end_x, end_y,
               rect_width, rect_height, ink,
        input  ready
    );

    modport sink (
        input  valid, action, start_x, start_y, end_x, end_y,
               rect_width, rect_height, ink,
        output ready
    );
endinterface

interface lrr_pixel_if
    import lrr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  pixel_ink;
    logic                  shape_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_ink, shape_done,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_ink, shape_done,
        output ready
    );
endinterface

### rtl/line_and_rectangle_rasterizer.sv
`timescale 1ns / 1ps
// A pixel beat passes through the input register and then the result register.
// Throughput: one item per cycle without output stalls; each next-pixel item advances one pixel.
// Start items load a shape and emit no beat; a new start abandons any shape in progress.
// Output stalls hold the result register and back-pressure the input register.
// Reset (rst_n low, asynchronous) empties both registers and leaves the block idle.
module line_and_rectangle_rasterizer
    import lrr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    lrr_item_if.sink    item,
    lrr_pixel_if.source pixel
);

    // Input register.
    logic                  item_vld_reg;
    logic                  item_vld_next;
    logic [ACT_BITS-1:0]   item_act_reg;
    logic [COORD_BITS-1:0] item_sx_reg;
    logic [COORD_BITS-1:0] item_sy_reg;
    logic [COORD_BITS-1:0] item_ex_reg;
    logic [COORD_BITS-1:0] item_ey_reg;
    logic [RECT_BITS-1:0]  item_rw_reg;
    logic [RECT_BITS-1:0]  item_rh_reg;
    logic                  item_ink_reg;

    // Result register.
    logic                  pix_vld_reg;
    logic                  pix_vld_next;
    logic [COORD_BITS-1:0] pix_x_reg;
    logic [COORD_BITS-1:0] pix_y_reg;
    logic                  pix_ink_reg;
    logic                  pix_done_reg;

    logic                  out_free;
    logic                  fire;
    logic                  item_take;
    logic [COORD_BITS-1:0] eng_x;
    logic [COORD_BITS-1:0] eng_y;
    pix_flags_t            eng_flags;

    // Handshake: the held item is processed when the result register can take a beat.
    assign out_free   = !pix_vld_reg || pixel.ready;
    assign fire       = item_vld_reg && out_free;
    assign item.ready = !item_vld_reg || fire;
    assign item_take  = item.valid && item.ready;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (item_take)
        begin
            item_vld_next = 1'b1;
        end
        else if (fire)
        begin
            item_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        pix_vld_next = pix_vld_reg;
        if (out_free)
        begin
            pix_vld_next = eng_flags.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            pix_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            pix_vld_reg  <= pix_vld_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_act_reg <= item.action;
            item_sx_reg  <= item.start_x;
            item_sy_reg  <= item.start_y;
            item_ex_reg  <= item.end_x;
            item_ey_reg  <= item.end_y;
            item_rw_reg  <= item.rect_width;
            item_rh_reg  <= item.rect_height;
            item_ink_reg <= item.ink;
        end
    end

    lrr_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .action      (item_act_reg),
        .start_x     (item_sx_reg),
        .start_y     (item_sy_reg),
        .end_x       (item_ex_reg),
        .end_y       (item_ey_reg),
        .rect_width  (item_rw_reg),
        .rect_height (item_rh_reg),
        .ink         (item_ink_reg),
        .pixel_x     (eng_x),
        .pixel_y     (eng_y),
        .flags       (eng_flags)
    );

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (out_free && eng_flags.emit)
        begin
            pix_x_reg    <= eng_x;
            pix_y_reg    <= eng_y;
            pix_ink_reg  <= eng_flags.ink;
            pix_done_reg <= eng_flags.done;
        end
    end

    assign pixel.valid      = pix_vld_reg;
    assign pixel.pixel_x    = pix_x_reg;
    assign pixel.pixel_y    = pix_y_reg;
    assign pixel.pixel_ink  = pix_ink_reg;
    assign pixel.shape_done = pix_done_reg;

endmodule

### rtl/lrr_line_setup.sv
`timescale 1ns / 1ps
// Bresenham line preparation: steep swap, endpoint ordering, deltas and initial error.
module lrr_line_setup
    import lrr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic [COORD_BITS-1:0] x0,
    input  logic [COORD_BITS-1:0] y0,
    input  logic [COORD_BITS-1:0] x1,
    input  logic [COORD_BITS-1:0] y1,
    output line_dir_t             dir,
    output logic [COORD_BITS-1:0] maj_start,
    output logic [COORD_BITS-1:0] min_start,
    output logic [COORD_BITS-1:0] maj_end,
    output logic [COORD_BITS-1:0] d_major,
    output logic [COORD_BITS-1:0] d_minor,
    output logic [COORD_BITS+1:0] err_init
);

    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] a0;
    logic [COORD_BITS-1:0] b0;
    logic [COORD_BITS-1:0] a1;
    logic [COORD_BITS-1:0] b1;
    logic [COORD_BITS-1:0] min_end;
    logic                  steep;
    logic                  swap;

    // Absolute spans along both axes.
    assign adx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    assign ady = (y1 > y0) ? (y1 - y0) : (y0 - y1);

    // A steep line steps along y, so the axes trade places.
    assign steep = ady > adx;
    assign a0    = steep ? y0 : x0;
    assign b0    = steep ? x0 : y0;
    assign a1    = steep ? y1 : x1;
    assign b1    = steep ? x1 : y1;

    // Order the endpoints so that the major coordinate increases.
    assign swap      = a0 > a1;
    assign maj_start = swap ? a1 : a0;
    assign min_start = swap ? b1 : b0;
    assign maj_end   = swap ? a0 : a1;
    assign min_end   = swap ? b0 : b1;

    // After ordering, the deltas are the axis spans.
    assign d_major = steep ? ady : adx;
    assign d_minor = steep ? adx : ady;

    assign dir.steep      = steep;
    assign dir.minor_down = !(min_start < min_end);

    // Error starts at half the major delta.
    assign err_init = {3'b000, d_major[COORD_BITS-1:1]};

endmodule

### rtl/lrr_engine.sv
`timescale 1ns / 1ps
// Shape state and Bresenham stepper: loads shapes and segments, advances one pixel per beat.
module lrr_engine
    import lrr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [ACT_BITS-1:0]   action,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [RECT_BITS-1:0]  rect_width,
    input  logic [RECT_BITS-1:0]  rect_height,
    input  logic                  ink,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output pix_flags_t            flags
);

    localparam int ERR_W = COORD_BITS + 2;
    localparam logic [COORD_BITS-1:0] C_ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

    // Control state.
    logic                  busy_reg;
    logic [ACT_BITS-1:0]   kind_reg;
    logic [RECT_BITS-1:0]  seg_idx_reg;

    // Shape geometry.
    logic                  ink_reg;
    logic [COORD_BITS-1:0] org_x_reg;
    logic [COORD_BITS-1:0] org_y_reg;
    logic [COORD_BITS-1:0] far_x_reg;
    logic [COORD_BITS-1:0] far_y_reg;
    logic [RECT_BITS-1:0]  col_cnt_reg;

    // Current line.
    logic [COORD_BITS-1:0] cur_major_reg;
    logic [COORD_BITS-1:0] cur_minor_reg;
    logic [COORD_BITS-1:0] end_major_reg;
    logic [ERR_W-1:0]      err_reg;
    logic [COORD_BITS-1:0] d_major_reg;
    logic [COORD_BITS-1:0] d_minor_reg;
    line_dir_t             dir_reg;

    logic [COORD_BITS+RECT_BITS-1:0] rw_ext;
    logic [COORD_BITS+RECT_BITS-1:0] rh_ext;
    logic [COORD_BITS+RECT_BITS-1:0] idx_ext;
    logic [COORD_BITS-1:0] rw_c;
    logic [COORD_BITS-1:0] rh_c;
    logic [COORD_BITS-1:0] idx_c;
    logic [COORD_BITS-1:0] far_x_new;
    logic [COORD_BITS-1:0] far_y_new;
    logic [COORD_BITS-1:0] col_x;
    logic [RECT_BITS-1:0]  next_idx;
    logic                  is_start;
    logic                  step;
    logic                  last;
    logic                  outline_more;
    logic                  filled_more;
    logic                  reload;
    logic                  done;
    logic                  load;

    logic [COORD_BITS-1:0] lx0;
    logic [COORD_BITS-1:0] ly0;
    logic [COORD_BITS-1:0] lx1;
    logic [COORD_BITS-1:0] ly1;
    line_dir_t             set_dir;
    logic [COORD_BITS-1:0] set_maj_start;
    logic [COORD_BITS-1:0] set_min_start;
    logic [COORD_BITS-1:0] set_maj_end;
    logic [COORD_BITS-1:0] set_d_major;
    logic [COORD_BITS-1:0] set_d_minor;
    logic [ERR_W-1:0]      set_err;

    logic [ERR_W-1:0]      err_sub;
    logic [ERR_W-1:0]      err_next;
    logic [COORD_BITS-1:0] cur_minor_next;

    // Rectangle sizes and column index brought to coordinate width.
    assign rw_ext  = {{COORD_BITS{1'b0}}, rect_width};
    assign rh_ext  = {{COORD_BITS{1'b0}}, rect_height};
    assign idx_ext = {{COORD_BITS{1'b0}}, next_idx};
    assign rw_c    = rw_ext[COORD_BITS-1:0];
    assign rh_c    = rh_ext[COORD_BITS-1:0];
    assign idx_c   = idx_ext[COORD_BITS-1:0];

    // Far corner of a rectangle, wrapping at the coordinate width.
    assign far_x_new = start_x + rw_c - C_ONE;
    assign far_y_new = start_y + rh_c - C_ONE;

    // Beat classification.
    assign is_start     = (action != ACT_NEXT);
    assign step         = fire && (action == ACT_NEXT) && busy_reg;
    assign last         = (cur_major_reg == end_major_reg);
    assign next_idx     = seg_idx_reg + 8'd1;
    assign col_x        = org_x_reg + idx_c;
    assign outline_more = (kind_reg == ACT_OUTLINE) && (seg_idx_reg < SEG_RIGHT);
    assign filled_more  = (kind_reg == ACT_FILLED) && (next_idx < col_cnt_reg);
    assign reload       = step && last && (outline_more || filled_more);
    assign done         = step && last && !(outline_more || filled_more);
    assign load         = (fire && is_start) || reload;

    // Endpoints of the line to prepare: a new shape, or the next segment or column.
    always_comb
    begin
        lx0 = org_x_reg;
        ly0 = org_y_reg;
        lx1 = org_x_reg;
        ly1 = org_y_reg;
        if (is_start)
        begin
            case (action)
                ACT_LINE:
                begin
                    lx0 = start_x;
                    ly0 = start_y;
                    lx1 = end_x;
                    ly1 = end_y;
                end
                ACT_OUTLINE:
                begin
                    lx0 = start_x;
                    ly0 = start_y;
                    lx1 = far_x_new;
                    ly1 = start_y;
                end
                default:
                begin
                    lx0 = start_x;
                    ly0 = start_y;
                    lx1 = start_x;
                    ly1 = far_y_new;
                end
            endcase
        end
        else if (kind_reg == ACT_OUTLINE)
        begin
            case (next_idx)
                SEG_LEFT:
                begin
                    lx0 = org_x_reg;
                    ly0 = org_y_reg;
                    lx1 = org_x_reg;
                    ly1 = far_y_reg;
                end
                SEG_BOTTOM:
                begin
                    lx0 = far_x_reg;
                    ly0 = far_y_reg;
                    lx1 = org_x_reg;
                    ly1 = far_y_reg;
                end
                default:
                begin
                    lx0 = far_x_reg;
                    ly0 = far_y_reg;
                    lx1 = far_x_reg;
                    ly1 = org_y_reg;
                end
            endcase
        end
        else
        begin
            lx0 = col_x;
            ly0 = org_y_reg;
            lx1 = col_x;
            ly1 = far_y_reg;
        end
    end

    lrr_line_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x0        (lx0),
        .y0        (ly0),
        .x1        (lx1),
        .y1        (ly1),
        .dir       (set_dir),
        .maj_start (set_maj_start),
        .min_start (set_min_start),
        .maj_end   (set_maj_end),
        .d_major   (set_d_major),
        .d_minor   (set_d_minor),
        .err_init  (set_err)
    );

    // Bresenham step: subtract minor delta; on underflow add major delta and move the minor axis.
    always_comb
    begin
        err_sub        = err_reg - {2'b00, d_minor_reg};
        err_next       = err_sub;
        cur_minor_next = cur_minor_reg;
        if (err_sub[ERR_W-1])
        begin
            err_next       = err_sub + {2'b00, d_major_reg};
            cur_minor_next = dir_reg.minor_down ? (cur_minor_reg - C_ONE)
                                                : (cur_minor_reg + C_ONE);
        end
    end

    // Shape control: busy flag, kind and segment or column index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            kind_reg    <= ACT_LINE;
            seg_idx_reg <= '0;
        end
        else if (fire && is_start)
        begin
            kind_reg    <= action;
            seg_idx_reg <= '0;
            busy_reg    <= !((action == ACT_FILLED) && (rect_width == '0));
        end
        else if (reload)
        begin
            seg_idx_reg <= next_idx;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Shape geometry, latched at start.
    always_ff @(posedge clk)
    begin
        if (fire && is_start)
        begin
            ink_reg     <= ink;
            org_x_reg   <= start_x;
            org_y_reg   <= start_y;
            far_x_reg   <= far_x_new;
            far_y_reg   <= far_y_new;
            col_cnt_reg <= rect_width;
        end
    end

    // Line stepper registers: load a prepared line or advance one pixel.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dir_reg       <= set_dir;
            cur_major_reg <= set_maj_start;
            cur_minor_reg <= set_min_start;
            end_major_reg <= set_maj_end;
            d_major_reg   <= set_d_major;
            d_minor_reg   <= set_d_minor;
            err_reg       <= set_err;
        end
        else if (step && !last)
        begin
            err_reg       <= err_next;
            cur_minor_reg <= cur_minor_next;
            cur_major_reg <= cur_major_reg + C_ONE;
        end
    end

    // Current pixel, with the axes swapped back for steep lines.
    assign pixel_x    = dir_reg.steep ? cur_minor_reg : cur_major_reg;
    assign pixel_y    = dir_reg.steep ? cur_major_reg : cur_minor_reg;
    assign flags.emit = step;
    assign flags.ink  = ink_reg;
    assign flags.done = done;

    // The error term stays within zero and the major delta.
    a_err_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !err_reg[ERR_W-1])
        else $error("error term went negative");

    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (err_reg <= {2'b00, d_major_reg}))
        else $error("error term above major delta");

    a_outline_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (kind_reg == ACT_OUTLINE)) |-> (seg_idx_reg <= SEG_RIGHT))
        else $error("outline segment index out of range");

    a_filled_col: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (kind_reg == ACT_FILLED)) |-> (seg_idx_reg < col_cnt_reg))
        else $error("filled column index beyond width");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        flags.done |=> !busy_reg)
        else $error("still busy after the last pixel");

endmodule
